@@ rtl/chs_pkg.sv @@
// Shared widths, constants, control types and reciprocal tables for the CHS geometry unit.
package chs_pkg;

  localparam int unsigned SIZE_W  = 21;
  localparam int unsigned CYL_W   = 16;
  localparam int unsigned HEAD_W  = 5;
  localparam int unsigned SPT_W   = 8;
  localparam int unsigned BYTES_W = 37;

  localparam int unsigned SECTOR_BYTES    = 512;
  localparam int unsigned SB_W            = 13;
  localparam int unsigned SECTORS_PER_MIB = 1048576 / SECTOR_BYTES;
  localparam int unsigned TS_RAW_W        = SIZE_W + 12;

  localparam int unsigned MAX_CYLS  = 65535;
  localparam int unsigned MAX_HEADS = 16;
  localparam int unsigned SPT_BIG   = 255;
  localparam int unsigned SPT_LARGE = 63;
  localparam int unsigned SPT_SMALL = 17;
  localparam int unsigned SPT_MID   = 31;
  localparam int unsigned CYL_LIMIT = 1024;
  localparam int unsigned MIN_HEADS = 4;
  localparam int unsigned CL_SHIFT  = $clog2(CYL_LIMIT);

  localparam int unsigned TS_W = 29;
  localparam logic [TS_W-1:0] TS_MAX = TS_W'(MAX_CYLS * MAX_HEADS * SPT_BIG);
  localparam logic [TS_W-1:0] TS_BIG = TS_W'(MAX_CYLS * MAX_HEADS * SPT_LARGE);

  localparam int unsigned DIV_K   = TS_W;
  localparam int unsigned RECIP_W = 25;
  localparam int unsigned PROD_W  = TS_W + RECIP_W;
  localparam int unsigned QUOT_W  = 24;
  localparam int unsigned HRAW_W  = QUOT_W + 1 - CL_SHIFT;

  localparam logic [RECIP_W-1:0] RECIP_17  = RECIP_W'((64'd1 << DIV_K) / 64'd17);
  localparam logic [RECIP_W-1:0] RECIP_31  = RECIP_W'((64'd1 << DIV_K) / 64'd31);
  localparam logic [RECIP_W-1:0] RECIP_63  = RECIP_W'((64'd1 << DIV_K) / 64'd63);
  localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'((64'd1 << DIV_K) / 64'd255);

  localparam logic [SPT_W-1:0] SPT_SMALL_C = SPT_W'(SPT_SMALL);
  localparam logic [SPT_W-1:0] SPT_MID_C   = SPT_W'(SPT_MID);
  localparam logic [SPT_W-1:0] SPT_LARGE_C = SPT_W'(SPT_LARGE);
  localparam logic [SPT_W-1:0] SPT_BIG_C   = SPT_W'(SPT_BIG);

  localparam int unsigned CTH_W    = 20;
  localparam int unsigned HDIV_K   = CTH_W;
  localparam int unsigned HRECIP_W = 19;
  localparam int unsigned HS_W     = 12;
  localparam int unsigned CHS_W    = CYL_W + HS_W;

  typedef struct packed {
    logic load_prod;
    logic load_quot;
  } quot_en_t;

  // Reciprocal floor(2^20 / heads) for the head counts that can occur.
  function automatic logic [HRECIP_W-1:0] head_recip(input logic [HEAD_W-1:0] h);
    logic [HRECIP_W-1:0] r;
    begin
      case (h)
        5'd4:    r = 19'd262144;
        5'd5:    r = 19'd209715;
        5'd6:    r = 19'd174762;
        5'd7:    r = 19'd149796;
        5'd8:    r = 19'd131072;
        5'd9:    r = 19'd116508;
        5'd10:   r = 19'd104857;
        5'd11:   r = 19'd95325;
        5'd12:   r = 19'd87381;
        5'd13:   r = 19'd80659;
        5'd14:   r = 19'd74898;
        5'd15:   r = 19'd69905;
        5'd16:   r = 19'd65536;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ rtl/chs_if.sv @@
// Valid/ready channel interfaces for the request and result beats.
interface chs_in_if;
  import chs_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_mebibytes;
  modport source (output valid, output size_mebibytes, input ready);
  modport sink (input valid, input size_mebibytes, output ready);
endinterface

interface chs_out_if;
  import chs_pkg::*;
  logic               valid;
  logic               ready;
  logic [CYL_W-1:0]   cylinders;
  logic [HEAD_W-1:0]  heads;
  logic [SPT_W-1:0]   sectors_per_track;
  logic [BYTES_W-1:0] rounded_bytes;
  modport source (output valid, output cylinders, output heads, output sectors_per_track,
                  output rounded_bytes, input ready);
  modport sink (input valid, input cylinders, input heads, input sectors_per_track,
                input rounded_bytes, output ready);
endinterface

@@ rtl/chs_quot.sv @@
// Two-stage reciprocal dividers giving the sector count over 17, 31, 63 and 255.
module chs_quot (
  input  logic                     clk,
  input  chs_pkg::quot_en_t        en,
  input  logic [chs_pkg::TS_W-1:0] ts,
  output logic [chs_pkg::QUOT_W-1:0] q17,
  output logic [chs_pkg::QUOT_W-1:0] q31,
  output logic [chs_pkg::QUOT_W-1:0] q63,
  output logic [chs_pkg::QUOT_W-1:0] q255
);
  import chs_pkg::*;

  // The estimate is low by at most one, so one compare fixes it.
  function automatic logic [QUOT_W-1:0] fix_quot(input logic [TS_W-1:0] n,
                                                 input logic [RECIP_W-1:0] q0,
                                                 input logic [SPT_W-1:0] d);
    logic [RECIP_W+SPT_W-1:0] qd;
    logic [TS_W-1:0]          rem;
    logic                     ge;
    begin
      qd  = {{SPT_W{1'b0}}, q0} * {{RECIP_W{1'b0}}, d};
      rem = n - qd[TS_W-1:0];
      ge  = rem >= {{(TS_W-SPT_W){1'b0}}, d};
      return QUOT_W'(q0 + {{(RECIP_W-1){1'b0}}, ge});
    end
  endfunction

  logic [TS_W-1:0]   ts_r;
  logic [PROD_W-1:0] p17_r, p31_r, p63_r, p255_r;
  logic [PROD_W-1:0] p17_nxt, p31_nxt, p63_nxt, p255_nxt;
  logic [QUOT_W-1:0] q17_r, q31_r, q63_r, q255_r;
  logic [QUOT_W-1:0] q17_nxt, q31_nxt, q63_nxt, q255_nxt;

  assign p17_nxt  = {{RECIP_W{1'b0}}, ts} * {{TS_W{1'b0}}, RECIP_17};
  assign p31_nxt  = {{RECIP_W{1'b0}}, ts} * {{TS_W{1'b0}}, RECIP_31};
  assign p63_nxt  = {{RECIP_W{1'b0}}, ts} * {{TS_W{1'b0}}, RECIP_63};
  assign p255_nxt = {{RECIP_W{1'b0}}, ts} * {{TS_W{1'b0}}, RECIP_255};

  always_ff @(posedge clk) begin
    if (en.load_prod) begin
      ts_r   <= ts;
      p17_r  <= p17_nxt;
      p31_r  <= p31_nxt;
      p63_r  <= p63_nxt;
      p255_r <= p255_nxt;
    end
  end

  assign q17_nxt  = fix_quot(ts_r, p17_r[PROD_W-1:DIV_K], SPT_SMALL_C);
  assign q31_nxt  = fix_quot(ts_r, p31_r[PROD_W-1:DIV_K], SPT_MID_C);
  assign q63_nxt  = fix_quot(ts_r, p63_r[PROD_W-1:DIV_K], SPT_LARGE_C);
  assign q255_nxt = fix_quot(ts_r, p255_r[PROD_W-1:DIV_K], SPT_BIG_C);

  always_ff @(posedge clk) begin
    if (en.load_quot) begin
      q17_r  <= q17_nxt;
      q31_r  <= q31_nxt;
      q63_r  <= q63_nxt;
      q255_r <= q255_nxt;
    end
  end

  assign q17  = q17_r;
  assign q31  = q31_r;
  assign q63  = q63_r;
  assign q255 = q255_r;

endmodule

@@ rtl/chs_geometry_from_size_unit.sv @@
// Top level: eight-stage pipeline from disk size to CHS geometry and rounded byte size.
// Throughput is one beat per cycle while the output is ready; every stage holds one item with its own valid bit.
// A stalled stage holds while earlier stages keep filling any empty slots behind it.
// The stages are the clamp, two reciprocal-divider stages, geometry selection, two
// stages dividing by the head count, and two multiply stages for the byte size.
// Synchronous active-low reset clears the valid bits; the data registers are not reset.
module chs_geometry_from_size_unit (
  input  logic      clk,
  input  logic      rst_n,
  chs_in_if.sink    in_chan,
  chs_out_if.source out_chan
);
  import chs_pkg::*;

  localparam int unsigned NSTG = 8;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_chan.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && in_chan.valid;
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = rdy[k] && v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_chan.ready = rdy[0];

  // Sector count, clamped to the largest geometry.
  logic [TS_RAW_W-1:0] ts_raw_nxt;
  logic [TS_W-1:0]     ts_nxt;
  logic [TS_W-1:0]     s1_ts_r;
  logic                s1_big_r, s2_big_r, s3_big_r;

  assign ts_raw_nxt = {{(TS_RAW_W-SIZE_W){1'b0}}, in_chan.size_mebibytes} *
                      TS_RAW_W'(SECTORS_PER_MIB);
  assign ts_nxt = (ts_raw_nxt > {{(TS_RAW_W-TS_W){1'b0}}, TS_MAX}) ? TS_MAX
                                                                  : ts_raw_nxt[TS_W-1:0];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_ts_r  <= ts_nxt;
      s1_big_r <= ts_nxt >= TS_BIG;
    end
    if (ld[1]) begin
      s2_big_r <= s1_big_r;
    end
    if (ld[2]) begin
      s3_big_r <= s2_big_r;
    end
  end

  quot_en_t          qen;
  logic [QUOT_W-1:0] q17, q31, q63, q255;

  assign qen.load_prod = ld[1];
  assign qen.load_quot = ld[2];

  chs_quot u_quot (
    .clk  (clk),
    .en   (qen),
    .ts   (s1_ts_r),
    .q17  (q17),
    .q31  (q31),
    .q63  (q63),
    .q255 (q255)
  );

  // Geometry selection.
  logic [QUOT_W:0]     hsum;
  logic [HRAW_W-1:0]   hraw;
  logic [HRAW_W-1:0]   hmin;
  logic [QUOT_W:0]     lim17;
  logic                fail17;
  logic                fail31;
  logic [SPT_W-1:0]    spt_nxt;
  logic [HEAD_W-1:0]   heads_nxt;
  logic [CTH_W-1:0]    cth_nxt;
  logic [SPT_W-1:0]    s4_spt_r;
  logic [HEAD_W-1:0]   s4_heads_r;
  logic [CTH_W-1:0]    s4_cth_r;

  always_comb begin
    hsum   = {1'b0, q17} + (QUOT_W+1)'(CYL_LIMIT - 1);
    hraw   = hsum[QUOT_W:CL_SHIFT];
    hmin   = (hraw < HRAW_W'(MIN_HEADS)) ? HRAW_W'(MIN_HEADS) : hraw;
    lim17  = {hmin, {CL_SHIFT{1'b0}}};
    fail17 = ({1'b0, q17} >= lim17) || (hmin > HRAW_W'(MAX_HEADS));
    fail31 = q31 >= QUOT_W'(MAX_HEADS * CYL_LIMIT);
    if (s3_big_r) begin
      spt_nxt   = SPT_BIG_C;
      heads_nxt = HEAD_W'(MAX_HEADS);
      cth_nxt   = q255[CTH_W-1:0];
    end else if (!fail17) begin
      spt_nxt   = SPT_SMALL_C;
      heads_nxt = hmin[HEAD_W-1:0];
      cth_nxt   = q17[CTH_W-1:0];
    end else if (!fail31) begin
      spt_nxt   = SPT_MID_C;
      heads_nxt = HEAD_W'(MAX_HEADS);
      cth_nxt   = q31[CTH_W-1:0];
    end else begin
      spt_nxt   = SPT_LARGE_C;
      heads_nxt = HEAD_W'(MAX_HEADS);
      cth_nxt   = q63[CTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_spt_r   <= spt_nxt;
      s4_heads_r <= heads_nxt;
      s4_cth_r   <= cth_nxt;
    end
  end

  // Cylinders: cylinder-times-heads over heads, by table reciprocal and one correction.
  logic [CTH_W+HRECIP_W-1:0] s5_prod_r;
  logic [HS_W-1:0]           s5_hs_r;
  logic [CTH_W-1:0]          s5_cth_r;
  logic [HEAD_W-1:0]         s5_heads_r;
  logic [SPT_W-1:0]          s5_spt_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_prod_r  <= {{HRECIP_W{1'b0}}, s4_cth_r} *
                    {{CTH_W{1'b0}}, head_recip(s4_heads_r)};
      s5_hs_r    <= {{(HS_W-HEAD_W){1'b0}}, s4_heads_r} * {{(HS_W-SPT_W){1'b0}}, s4_spt_r};
      s5_cth_r   <= s4_cth_r;
      s5_heads_r <= s4_heads_r;
      s5_spt_r   <= s4_spt_r;
    end
  end

  logic [HRECIP_W-1:0]        hq0;
  logic [HRECIP_W+HEAD_W-1:0] hqh;
  logic [CTH_W-1:0]           hrem;
  logic                       hge;
  logic [HRECIP_W-1:0]        cyl_full;
  logic [CYL_W-1:0]           s6_cyl_r;
  logic [HS_W-1:0]            s6_hs_r;
  logic [HEAD_W-1:0]          s6_heads_r;
  logic [SPT_W-1:0]           s6_spt_r;

  always_comb begin
    hq0      = s5_prod_r[CTH_W+HRECIP_W-1:HDIV_K];
    hqh      = {{HEAD_W{1'b0}}, hq0} * {{HRECIP_W{1'b0}}, s5_heads_r};
    hrem     = s5_cth_r - hqh[CTH_W-1:0];
    hge      = hrem >= {{(CTH_W-HEAD_W){1'b0}}, s5_heads_r};
    cyl_full = hq0 + {{(HRECIP_W-1){1'b0}}, hge};
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_cyl_r   <= cyl_full[CYL_W-1:0];
      s6_hs_r    <= s5_hs_r;
      s6_heads_r <= s5_heads_r;
      s6_spt_r   <= s5_spt_r;
    end
  end

  // Rounded byte size.
  logic [CHS_W-1:0]       s7_chs_r;
  logic [CYL_W-1:0]       s7_cyl_r;
  logic [HEAD_W-1:0]      s7_heads_r;
  logic [SPT_W-1:0]       s7_spt_r;
  logic [CHS_W+SB_W-1:0]  bytes_full;
  logic [BYTES_W-1:0]     s8_bytes_r;
  logic [CYL_W-1:0]       s8_cyl_r;
  logic [HEAD_W-1:0]      s8_heads_r;
  logic [SPT_W-1:0]       s8_spt_r;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s7_chs_r   <= {{HS_W{1'b0}}, s6_cyl_r} * {{CYL_W{1'b0}}, s6_hs_r};
      s7_cyl_r   <= s6_cyl_r;
      s7_heads_r <= s6_heads_r;
      s7_spt_r   <= s6_spt_r;
    end
  end

  assign bytes_full = {{SB_W{1'b0}}, s7_chs_r} * {{CHS_W{1'b0}}, SB_W'(SECTOR_BYTES)};

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s8_bytes_r <= bytes_full[BYTES_W-1:0];
      s8_cyl_r   <= s7_cyl_r;
      s8_heads_r <= s7_heads_r;
      s8_spt_r   <= s7_spt_r;
    end
  end

  assign out_chan.valid             = v_r[NSTG-1];
  assign out_chan.cylinders         = s8_cyl_r;
  assign out_chan.heads             = s8_heads_r;
  assign out_chan.sectors_per_track = s8_spt_r;
  assign out_chan.rounded_bytes     = s8_bytes_r;

`ifndef SYNTHESIS
  a_heads_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.heads >= HEAD_W'(MIN_HEADS)) &&
                       (out_chan.heads <= HEAD_W'(MAX_HEADS)))
    else $error("heads out of range on a result beat");

  a_spt_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.sectors_per_track == SPT_SMALL_C) ||
                       (out_chan.sectors_per_track == SPT_MID_C) ||
                       (out_chan.sectors_per_track == SPT_LARGE_C) ||
                       (out_chan.sectors_per_track == SPT_BIG_C))
    else $error("sectors per track is not a legal geometry");

  a_full_heads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.sectors_per_track != SPT_SMALL_C)) |->
      (out_chan.heads == HEAD_W'(MAX_HEADS)))
    else $error("large geometry without sixteen heads");

  a_small_cyls: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && ((out_chan.sectors_per_track == SPT_SMALL_C) ||
                        (out_chan.sectors_per_track == SPT_MID_C))) |->
      (out_chan.cylinders < CYL_W'(CYL_LIMIT)))
    else $error("cylinder limit exceeded for a small geometry");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> v_r[0])
    else $error("accepted request beat did not enter the first stage");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the CHS geometry unit: directed, random and back-pressure tests.
module tb;
  import chs_pkg::*;

  typedef struct packed {
    logic [CYL_W-1:0]   cylinders;
    logic [HEAD_W-1:0]  heads;
    logic [SPT_W-1:0]   sectors_per_track;
    logic [BYTES_W-1:0] rounded_bytes;
  } geom_t;

  localparam longint unsigned GEO_CYLS      = 64'd65535;
  localparam longint unsigned GEO_HEADS     = 64'd16;
  localparam longint unsigned GEO_MIN_HEADS = 64'd4;
  localparam longint unsigned GEO_CYL_SPAN  = 64'd1024;
  localparam longint unsigned GEO_SPT_17    = 64'd17;
  localparam longint unsigned GEO_SPT_31    = 64'd31;
  localparam longint unsigned GEO_SPT_63    = 64'd63;
  localparam longint unsigned GEO_SPT_255   = 64'd255;
  localparam longint unsigned GEO_SECT_CAP  = GEO_CYLS * GEO_HEADS * GEO_SPT_255;
  localparam longint unsigned GEO_SECT_BIG  = GEO_CYLS * GEO_HEADS * GEO_SPT_63;
  localparam int unsigned     SIZE_TOP      = (1 << SIZE_W) - 1;

  logic clk;
  logic rst_n;

  chs_in_if  in_chan ();
  chs_out_if out_chan ();

  chs_geometry_from_size_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  geom_t pending_geoms[$];
  int    mismatches    = 0;
  bit    send_gaps_on  = 1'b1;
  bit    sink_gaps_on  = 1'b1;
  int    long_hold_req = 0;
  int    sink_stall    = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic geom_t geometry_for_size(input logic [SIZE_W-1:0] mib);
    longint unsigned sectors;
    longint unsigned spt;
    longint unsigned hd;
    longint unsigned cth;
    longint unsigned cyl;
    longint unsigned bytes;
    geom_t g;
    sectors = (64'(mib) * 64'd1048576) / 64'(SECTOR_BYTES);
    if (sectors > GEO_SECT_CAP) sectors = GEO_SECT_CAP;
    if (sectors >= GEO_SECT_BIG) begin
      spt = GEO_SPT_255;
      hd  = GEO_HEADS;
      cth = sectors / spt;
    end else begin
      spt = GEO_SPT_17;
      cth = sectors / spt;
      hd  = (cth + GEO_CYL_SPAN - 1) / GEO_CYL_SPAN;
      if (hd < GEO_MIN_HEADS) hd = GEO_MIN_HEADS;
      if (cth >= hd * GEO_CYL_SPAN || hd > GEO_HEADS) begin
        spt = GEO_SPT_31;
        hd  = GEO_HEADS;
        cth = sectors / spt;
      end
      if (cth >= hd * GEO_CYL_SPAN) begin
        spt = GEO_SPT_63;
        hd  = GEO_HEADS;
        cth = sectors / spt;
      end
    end
    cyl   = cth / hd;
    bytes = cyl * hd * spt * 64'(SECTOR_BYTES);
    g.cylinders         = CYL_W'(cyl);
    g.heads             = HEAD_W'(hd);
    g.sectors_per_track = SPT_W'(spt);
    g.rounded_bytes     = BYTES_W'(bytes);
    return g;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    int r;
    int unsigned edges[$];
    edges = '{136, 137, 247, 248, 32255, 32256, 130558, 130559};
    r = $urandom_range(0, 99);
    if (r < 40) return SIZE_W'($urandom_range(0, 300));
    if (r < 65) return SIZE_W'($urandom_range(0, 33000));
    if (r < 80) return SIZE_W'($urandom_range(32000, 131000));
    if (r < 88) return SIZE_W'(edges[$urandom_range(0, 7)] + $urandom_range(0, 4) - 2);
    return SIZE_W'($urandom_range(0, SIZE_TOP));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_geometry();
    geom_t want;
    if (pending_geoms.size() == 0) begin
      report_mismatch("result beat with no request outstanding");
    end else begin
      want = pending_geoms.pop_front();
      if (out_chan.cylinders !== want.cylinders)
        report_mismatch($sformatf("cylinders %0d, expected %0d",
                                  out_chan.cylinders, want.cylinders));
      if (out_chan.heads !== want.heads)
        report_mismatch($sformatf("heads %0d, expected %0d", out_chan.heads, want.heads));
      if (out_chan.sectors_per_track !== want.sectors_per_track)
        report_mismatch($sformatf("sectors per track %0d, expected %0d",
                                  out_chan.sectors_per_track, want.sectors_per_track));
      if (out_chan.rounded_bytes !== want.rounded_bytes)
        report_mismatch($sformatf("rounded bytes %0d, expected %0d",
                                  out_chan.rounded_bytes, want.rounded_bytes));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) check_geometry();
    if (long_hold_req > 0) begin
      sink_stall    = long_hold_req;
      long_hold_req = 0;
    end else if (sink_stall == 0 && sink_gaps_on && $urandom_range(0, 99) < 30) begin
      sink_stall = pick_gap();
    end
    if (sink_stall > 0) begin
      out_chan.ready <= 1'b0;
      sink_stall--;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Called at a rising edge; valid stays high between beats when there is no gap.
  task automatic send_size(input logic [SIZE_W-1:0] mib);
    int gap;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.size_mebibytes <= mib;
    do @(posedge clk); while (!in_chan.ready);
    pending_geoms.push_back(geometry_for_size(mib));
  endtask

  task automatic test_directed_sizes();
    logic [SIZE_W-1:0] sizes[$];
    sizes = '{0, 1, 2, 16, 17, 34, 35, 51, 136, 137, 247, 248, 4095, 32255, 32256,
              65535, 130558, 130559, 130560, 1048576, 21'h155555, 21'h0AAAAA, SIZE_TOP};
    foreach (sizes[i]) send_size(sizes[i]);
  endtask

  task automatic test_small_sizes(input int count);
    repeat (count) send_size(SIZE_W'($urandom_range(0, 300)));
  endtask

  task automatic test_random_sizes(input int count);
    repeat (count) send_size(random_size());
  endtask

  task automatic test_back_to_back(input int count);
    send_gaps_on = 1'b0;
    sink_gaps_on = 1'b0;
    repeat (count) send_size(random_size());
    send_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    send_gaps_on  = 1'b0;
    long_hold_req = 150;
    repeat (40) send_size(random_size());
    send_gaps_on = 1'b1;
  endtask

  initial begin
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.size_mebibytes <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_sizes();
    test_small_sizes(250);
    test_random_sizes(500);
    test_back_to_back(150);
    test_output_backpressure();
    test_random_sizes(300);
    in_chan.valid <= 1'b0;
    while (pending_geoms.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ chs_geometry_from_size_unit.f @@
rtl/chs_pkg.sv
rtl/chs_if.sv
rtl/chs_quot.sv
rtl/chs_geometry_from_size_unit.sv
verif/tb.sv
